// ----- rtl/core/dual_tree_rrt_grow_step_core_macros.svh -----
// Assertion macros used by the grow step core checker.
`ifndef DUAL_TREE_RRT_GROW_STEP_CORE_MACROS_SVH
`define DUAL_TREE_RRT_GROW_STEP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTRRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTRRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dtrrt_pkg.sv -----
// Types and codes shared by the dual tree grow step core and its checker.
package dtrrt_pkg;

  // Fixed widths of the command and result words.
  localparam int OUT_CW = 8;
  localparam int IDX_W  = 16;
  localparam int PATH_W = 18;
  localparam int SIZE_W = 17;

  // Command function codes.
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_MARK   = 2'd1;
  localparam logic [1:0] FUNC_GROW   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_ACK       = 3'd0;
  localparam logic [2:0] ST_SAME      = 3'd1;
  localparam logic [2:0] ST_BLOCKED   = 3'd2;
  localparam logic [2:0] ST_ADDED     = 3'd3;
  localparam logic [2:0] ST_CONNECTED = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_ALREADY   = 3'd6;
  localparam logic [2:0] ST_NOT_START = 3'd7;

  typedef struct packed {
    logic [1:0]        func;
    logic [OUT_CW-1:0] coord_x;
    logic [OUT_CW-1:0] coord_y;
    logic [OUT_CW-1:0] coord_z;
    logic              snap_to_other_root;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              grew_start_tree;
    logic [OUT_CW-1:0] new_x;
    logic [OUT_CW-1:0] new_y;
    logic [OUT_CW-1:0] new_z;
    logic [IDX_W-1:0]  new_index;
    logic [IDX_W-1:0]  partner_index;
    logic [PATH_W-1:0] path_len;
    logic [SIZE_W-1:0] start_size;
    logic [SIZE_W-1:0] goal_size;
  } res_t;

endpackage

// ----- rtl/core/dual_tree_rrt_grow_step_core.sv -----
// A start word passes through S_INIT0 and S_INIT1 and an obstacle word through S_MRD and S_MWR;
// ack and rejected grow words are answered from idle. A grow word scans the active tree and then,
// once a node is added, the other tree, one node per cycle on the single read port of the tree memory.
// One word is processed at a time; each result shows for one cycle on done_o.
// After reset the obstacle map is cleared one row per cycle, with busy high; both trees start empty (not started).
module dual_tree_rrt_grow_step_core #(
  parameter int COORD_BITS = 8,
  parameter int MAX_NODES  = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  dtrrt_pkg::cmd_t cmd_i,
  output logic            busy,
  output logic            done_o,
  output dtrrt_pkg::res_t res_o
);
  import dtrrt_pkg::*;

  localparam int CB         = COORD_BITS;
  localparam int NB         = $clog2(MAX_NODES);
  localparam int CNT_W      = NB + 1;
  localparam int DW         = ((CB > OUT_CW) ? CB : OUT_CW) + 2;
  localparam int SQW        = 2 * DW;
  localparam int SUMW       = SQW + 2;
  localparam int SIDE       = 2 ** CB;
  localparam int ROW_W      = 2 * CB;
  localparam int MAP_ROWS   = 2 ** ROW_W;
  localparam int TREE_DEPTH = 2 * (2 ** NB);

  // Controller states.
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MRD   = 4'd2;
  localparam logic [3:0] S_MWR   = 4'd3;
  localparam logic [3:0] S_INIT0 = 4'd4;
  localparam logic [3:0] S_INIT1 = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_STEP  = 4'd7;
  localparam logic [3:0] S_BRD   = 4'd8;
  localparam logic [3:0] S_BCHK  = 4'd9;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    logic [NB-1:0] depth;
  } node_t;

  // Storage.
  node_t            node_store [TREE_DEPTH];
  logic [SIDE-1:0]  map_mem  [MAP_ROWS];
  node_t            tr_rdata_q;
  logic [SIDE-1:0]  map_rdata_q;

  // Control and datapath registers.
  logic [3:0]        state_q;
  logic [ROW_W-1:0]  clr_q;
  logic [CNT_W-1:0]  scnt_q, gcnt_q;
  logic              conn_q, act_q;
  logic signed [DW-1:0] tgt_x_q, tgt_y_q, tgt_z_q;
  logic [CNT_W-1:0]  iss_q, lim_q;
  logic              sel_q, phase_q;
  logic              rd_v_q, v2_q;
  logic [NB-1:0]     rd_idx_q, idx2_q;
  node_t             n2_q;
  logic [SQW-1:0]    sq2x_q, sq2y_q, sq2z_q;
  logic              bestv_q;
  logic [SUMW-1:0]   bestd_q;
  node_t             best_q;
  logic [SQW-1:0]    bsqx_q, bsqy_q, bsqz_q;
  logic              found_q;
  logic [NB-1:0]     part_q, pdep_q, new_idx_q, new_dep_q;
  res_t              res_q;
  logic              done_q;

  // Memory port controls.
  logic                 tr_we, tr_re;
  logic [NB:0]          tr_waddr, tr_raddr;
  node_t                tr_wdata;
  logic                 mp_we, mp_re;
  logic [ROW_W-1:0]     mp_waddr, mp_raddr;
  logic [SIDE-1:0]      mp_wdata;

  // Combinational helpers.
  logic                 accept, act_c, in_grid_c, oob_c, scan_end;
  logic [CNT_W-1:0]     acount, ocount, cnt_act_c;
  logic signed [DW-1:0] dx_c, dy_c, dz_c;
  logic signed [SQW-1:0] sqx_c, sqy_c, sqz_c;
  logic [SUMW-1:0]      sum2_c;
  logic signed [DW-1:0] bx_c, by_c, bz_c, ex_c, ey_c, ez_c;
  logic signed [DW-1:0] stx_c, sty_c, stz_c;
  logic [ROW_W-1:0]     tgt_row;
  logic [NB+1:0]        path_c;
  res_t                 res_base;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign done_o  = done_q;
  assign res_o   = res_q;

  // Active tree choice: the smaller one, ties to the start tree.
  assign act_c     = (scnt_q <= gcnt_q);
  assign cnt_act_c = act_c ? scnt_q : gcnt_q;
  assign acount    = act_q ? scnt_q : gcnt_q;
  assign ocount    = act_q ? gcnt_q : scnt_q;
  assign in_grid_c = ((DW - 1)'(cmd_i.coord_x) < (DW - 1)'(SIDE)) &&
                     ((DW - 1)'(cmd_i.coord_y) < (DW - 1)'(SIDE)) &&
                     ((DW - 1)'(cmd_i.coord_z) < (DW - 1)'(SIDE));
  assign tgt_row   = {tgt_x_q[CB-1:0], tgt_y_q[CB-1:0]};
  assign oob_c     = tgt_x_q[DW-1] || (tgt_x_q[DW-2:0] >= (DW - 1)'(SIDE)) ||
                     tgt_y_q[DW-1] || (tgt_y_q[DW-2:0] >= (DW - 1)'(SIDE)) ||
                     tgt_z_q[DW-1] || (tgt_z_q[DW-2:0] >= (DW - 1)'(SIDE));
  assign scan_end  = (iss_q == lim_q) && !rd_v_q && !v2_q;

  // Scan stage two: per-axis differences and squares of the node just read.
  assign dx_c   = tgt_x_q - $signed(DW'(tr_rdata_q.x));
  assign dy_c   = tgt_y_q - $signed(DW'(tr_rdata_q.y));
  assign dz_c   = tgt_z_q - $signed(DW'(tr_rdata_q.z));
  assign sqx_c  = SQW'(dx_c) * SQW'(dx_c);
  assign sqy_c  = SQW'(dy_c) * SQW'(dy_c);
  assign sqz_c  = SQW'(dz_c) * SQW'(dz_c);
  // Scan stage three: squared distance.
  assign sum2_c = SUMW'(sq2x_q) + SUMW'(sq2y_q) + SUMW'(sq2z_q);

  // Unit step from the nearest node; an axis moves when 4*d^2 >= total.
  assign bx_c  = $signed(DW'(best_q.x));
  assign by_c  = $signed(DW'(best_q.y));
  assign bz_c  = $signed(DW'(best_q.z));
  assign ex_c  = tgt_x_q - bx_c;
  assign ey_c  = tgt_y_q - by_c;
  assign ez_c  = tgt_z_q - bz_c;
  assign stx_c = ({bsqx_q, 2'b00} < bestd_q) ? '0 : ((ex_c > 0) ? DW'(1) : '1);
  assign sty_c = ({bsqy_q, 2'b00} < bestd_q) ? '0 : ((ey_c > 0) ? DW'(1) : '1);
  assign stz_c = ({bsqz_q, 2'b00} < bestd_q) ? '0 : ((ez_c > 0) ? DW'(1) : '1);

  assign path_c = (NB + 2)'(new_dep_q) + (NB + 2)'(pdep_q) + (NB + 2)'(2);

  // Default result word: zero fields and the current tree sizes.
  always_comb begin
    res_base            = '0;
    res_base.start_size = SIZE_W'(scnt_q);
    res_base.goal_size  = SIZE_W'(gcnt_q);
  end

  // Tree memory port controls.
  always_comb begin
    tr_we    = 1'b0;
    tr_waddr = '0;
    tr_wdata = '0;
    tr_re    = (state_q == S_SCAN) && (iss_q < lim_q);
    tr_raddr = {sel_q, iss_q[NB-1:0]};
    case (state_q)
      S_INIT0: begin
        tr_we = 1'b1;
      end
      S_INIT1: begin
        tr_we      = 1'b1;
        tr_waddr   = {1'b1, NB'(0)};
        tr_wdata.x = '1;
        tr_wdata.y = '1;
        tr_wdata.z = '1;
      end
      S_BCHK: begin
        tr_we          = !map_rdata_q[tgt_z_q[CB-1:0]];
        tr_waddr       = {!act_q, acount[NB-1:0]};
        tr_wdata.x     = tgt_x_q[CB-1:0];
        tr_wdata.y     = tgt_y_q[CB-1:0];
        tr_wdata.z     = tgt_z_q[CB-1:0];
        tr_wdata.depth = best_q.depth + NB'(1);
      end
      default: begin
      end
    endcase
  end

  // Obstacle map port controls.
  always_comb begin
    mp_re    = (state_q == S_MRD) || (state_q == S_BRD);
    mp_raddr = tgt_row;
    mp_we    = (state_q == S_CLR) || (state_q == S_MWR);
    mp_waddr = (state_q == S_CLR) ? clr_q : tgt_row;
    mp_wdata = (state_q == S_CLR) ? '0 :
               (map_rdata_q | (SIDE'(1) << tgt_z_q[CB-1:0]));
  end

  // Tree node memory.
  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      node_store[tr_waddr] <= tr_wdata;
    end
    if (tr_re) begin
      tr_rdata_q <= node_store[tr_raddr];
    end
  end

  // Obstacle map memory, one z-line per row.
  always_ff @(posedge clk_i) begin
    if (mp_we) begin
      map_mem[mp_waddr] <= mp_wdata;
    end
    if (mp_re) begin
      map_rdata_q <= map_mem[mp_raddr];
    end
  end

  // Scan pipeline payload.
  always_ff @(posedge clk_i) begin
    if (tr_re) begin
      rd_idx_q <= iss_q[NB-1:0];
    end
    if (rd_v_q) begin
      idx2_q <= rd_idx_q;
      n2_q   <= tr_rdata_q;
      sq2x_q <= SQW'(sqx_c);
      sq2y_q <= SQW'(sqy_c);
      sq2z_q <= SQW'(sqz_c);
    end
  end

  // Main controller.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      scnt_q    <= '0;
      gcnt_q    <= '0;
      conn_q    <= 1'b0;
      act_q     <= 1'b0;
      rd_v_q    <= 1'b0;
      v2_q      <= 1'b0;
      bestv_q   <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
      iss_q     <= '0;
      lim_q     <= '0;
      sel_q     <= 1'b0;
      phase_q   <= 1'b0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      tgt_z_q   <= '0;
      bestd_q   <= '0;
      best_q    <= '0;
      bsqx_q    <= '0;
      bsqy_q    <= '0;
      bsqz_q    <= '0;
      part_q    <= '0;
      pdep_q    <= '0;
      new_idx_q <= '0;
      new_dep_q <= '0;
      res_q     <= '0;
    end else begin
      done_q <= 1'b0;
      rd_v_q <= tr_re;
      v2_q   <= rd_v_q;
      case (state_q)
        // Clear the obstacle map row by row after reset.
        S_CLR: begin
          clr_q <= clr_q + ROW_W'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end

        // Take a command word and dispatch it.
        S_IDLE: begin
          if (accept) begin
            tgt_x_q <= $signed(DW'(cmd_i.coord_x));
            tgt_y_q <= $signed(DW'(cmd_i.coord_y));
            tgt_z_q <= $signed(DW'(cmd_i.coord_z));
            case (cmd_i.func)
              FUNC_START: begin
                state_q <= S_INIT0;
              end
              FUNC_MARK: begin
                if (in_grid_c) begin
                  state_q <= S_MRD;
                end else begin
                  res_q  <= res_base;
                  done_q <= 1'b1;
                end
              end
              FUNC_GROW: begin
                res_q  <= res_base;
                if (scnt_q == '0 || gcnt_q == '0) begin
                  res_q.status <= ST_NOT_START;
                  done_q       <= 1'b1;
                end else if (conn_q) begin
                  res_q.status <= ST_ALREADY;
                  done_q       <= 1'b1;
                end else if (cnt_act_c >= CNT_W'(MAX_NODES)) begin
                  res_q.status          <= ST_FULL;
                  res_q.grew_start_tree <= act_c;
                  done_q                <= 1'b1;
                end else begin
                  act_q   <= act_c;
                  sel_q   <= !act_c;
                  iss_q   <= '0;
                  lim_q   <= cnt_act_c;
                  phase_q <= 1'b0;
                  bestv_q <= 1'b0;
                  state_q <= S_SCAN;
                  if (cmd_i.snap_to_other_root) begin
                    tgt_x_q <= act_c ? $signed(DW'(SIDE - 1)) : '0;
                    tgt_y_q <= act_c ? $signed(DW'(SIDE - 1)) : '0;
                    tgt_z_q <= act_c ? $signed(DW'(SIDE - 1)) : '0;
                  end
                end
              end
              default: begin
                res_q  <= res_base;
                done_q <= 1'b1;
              end
            endcase
          end
        end

        // Obstacle: read the row, then write it back with the voxel set.
        S_MRD: begin
          state_q <= S_MWR;
        end
        S_MWR: begin
          res_q   <= res_base;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end

        // New plan: write both roots.
        S_INIT0: begin
          state_q <= S_INIT1;
        end
        S_INIT1: begin
          scnt_q           <= CNT_W'(1);
          gcnt_q           <= CNT_W'(1);
          conn_q           <= 1'b0;
          res_q            <= '0;
          res_q.start_size <= SIZE_W'(1);
          res_q.goal_size  <= SIZE_W'(1);
          done_q           <= 1'b1;
          state_q          <= S_IDLE;
        end

        // Tree scan, one node per cycle.
        S_SCAN: begin
          if (tr_re) begin
            iss_q <= iss_q + CNT_W'(1);
          end
          if (v2_q) begin
            if (!phase_q) begin
              if (!bestv_q || sum2_c < bestd_q) begin
                bestv_q <= 1'b1;
                bestd_q <= sum2_c;
                best_q  <= n2_q;
                bsqx_q  <= sq2x_q;
                bsqy_q  <= sq2y_q;
                bsqz_q  <= sq2z_q;
              end
            end else if (!found_q && sum2_c <= SUMW'(1)) begin
              found_q <= 1'b1;
              part_q  <= idx2_q;
              pdep_q  <= n2_q.depth;
            end
          end
          if (scan_end) begin
            if (!phase_q) begin
              state_q <= S_STEP;
            end else begin
              res_q                 <= res_base;
              res_q.grew_start_tree <= act_q;
              res_q.new_x           <= OUT_CW'(tgt_x_q);
              res_q.new_y           <= OUT_CW'(tgt_y_q);
              res_q.new_z           <= OUT_CW'(tgt_z_q);
              res_q.new_index       <= IDX_W'(new_idx_q);
              if (found_q) begin
                res_q.status        <= ST_CONNECTED;
                res_q.partner_index <= IDX_W'(part_q);
                res_q.path_len      <= PATH_W'(path_c);
                conn_q              <= 1'b1;
              end else begin
                res_q.status <= ST_ADDED;
              end
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end

        // Take the unit step, or report the sample as already reached.
        S_STEP: begin
          if (bestd_q == '0) begin
            res_q                 <= res_base;
            res_q.status          <= ST_SAME;
            res_q.grew_start_tree <= act_q;
            done_q                <= 1'b1;
            state_q               <= S_IDLE;
          end else begin
            tgt_x_q <= bx_c + stx_c;
            tgt_y_q <= by_c + sty_c;
            tgt_z_q <= bz_c + stz_c;
            state_q <= S_BRD;
          end
        end

        // Bounds check while the map row of the candidate is read.
        S_BRD: begin
          if (oob_c) begin
            res_q                 <= res_base;
            res_q.status          <= ST_BLOCKED;
            res_q.grew_start_tree <= act_q;
            res_q.new_x           <= OUT_CW'(tgt_x_q);
            res_q.new_y           <= OUT_CW'(tgt_y_q);
            res_q.new_z           <= OUT_CW'(tgt_z_q);
            done_q                <= 1'b1;
            state_q               <= S_IDLE;
          end else begin
            state_q <= S_BCHK;
          end
        end

        // Obstacle check; a free candidate is stored and the other tree scanned.
        S_BCHK: begin
          if (map_rdata_q[tgt_z_q[CB-1:0]]) begin
            res_q                 <= res_base;
            res_q.status          <= ST_BLOCKED;
            res_q.grew_start_tree <= act_q;
            res_q.new_x           <= OUT_CW'(tgt_x_q);
            res_q.new_y           <= OUT_CW'(tgt_y_q);
            res_q.new_z           <= OUT_CW'(tgt_z_q);
            done_q                <= 1'b1;
            state_q               <= S_IDLE;
          end else begin
            if (act_q) begin
              scnt_q <= scnt_q + CNT_W'(1);
            end else begin
              gcnt_q <= gcnt_q + CNT_W'(1);
            end
            new_idx_q <= acount[NB-1:0];
            new_dep_q <= best_q.depth + NB'(1);
            sel_q     <= act_q;
            iss_q     <= '0;
            lim_q     <= ocount;
            phase_q   <= 1'b1;
            found_q   <= 1'b0;
            state_q   <= S_SCAN;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/dtrrt_chk.sv -----
// Port-level checker for the dual tree grow step core, with its bind.
`include "dual_tree_rrt_grow_step_core_macros.svh"

module dtrrt_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input dtrrt_pkg::cmd_t cmd_i,
  input logic            done_o,
  input dtrrt_pkg::res_t res_o
);
  import dtrrt_pkg::*;

  logic             accepted_c, answered_c, not_started_c, empty_c, added_c, idx_ok_c;
  logic [IDX_W-1:0] last_idx_c;

  // Port conditions the assertions look at.
  assign accepted_c    = start && !busy;
  assign answered_c    = busy || done_o;
  assign not_started_c = done_o && (res_o.status == ST_NOT_START);
  assign empty_c       = (res_o.start_size == '0) && (res_o.goal_size == '0);
  assign added_c       = done_o && (res_o.status == ST_ADDED);
  assign last_idx_c    = res_o.grew_start_tree ? IDX_W'(res_o.start_size - SIZE_W'(1)) :
                                                 IDX_W'(res_o.goal_size - SIZE_W'(1));
  assign idx_ok_c      = (res_o.new_index == last_idx_c);

  // An accepted word either keeps the core busy or is answered next cycle.
  `DTRRT_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, accepted_c, answered_c, "word lost")

  // A result word is only shown once the core is back to idle.
  `DTRRT_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "result shown while busy")

  // Not started means both trees are empty.
  `DTRRT_ASSERT_IMP(a_not_started, clk_i, rst_ni, not_started_c, empty_c, "tree not empty")

  // An added node sits at the last index of the tree that grew.
  `DTRRT_ASSERT_IMP(a_added_index, clk_i, rst_ni, added_c, idx_ok_c, "added index mismatch")

endmodule

bind dual_tree_rrt_grow_step_core dtrrt_chk u_dtrrt_chk (.*);

// ----- tb/sv/dual_tree_rrt_grow_step_core_test.sv -----
// Self-checking testbench for the dual tree grow step core.
module dual_tree_rrt_grow_step_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dtrrt_pkg::*;

  localparam int SIDE = 256;
  localparam int MAXN = 65536;
  localparam int IDLE_LIMIT = 400000;

  // Node of a tree as the predictor keeps it.
  typedef struct {
    int x;
    int y;
    int z;
    int depth;
  } tree_node_t;

  // Row of the directed table; check_direct marks a typed-in expectation.
  typedef struct {
    cmd_t word;
    bit   check_direct;
    res_t direct_res;
  } vector_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  logic done_o;
  res_t res_o;

  // Predictor state.
  bit         blocked_vox[int];
  tree_node_t fwd_tree[$];
  tree_node_t back_tree[$];
  int         fwd_count;
  int         back_count;
  bit         joined;

  res_t pending_results[$];
  int   error_count = 0;
  int   table_errors = 0;
  int   idle_cycles = 0;

  dual_tree_rrt_grow_step_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int sq_dist(int ax, int ay, int az, tree_node_t b);
    int dx;
    int dy;
    int dz;
    dx = ax - b.x;
    dy = ay - b.y;
    dz = az - b.z;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic int unit_move(int d, int total);
    if (4 * d * d < total) return 0;
    return (d > 0) ? 1 : -1;
  endfunction

  // Works out the result of one word and updates the predictor state.
  function automatic res_t predict_grow_step(cmd_t w);
    res_t       r;
    bit         use_fwd;
    tree_node_t near_node;
    tree_node_t fresh;
    tree_node_t other;
    int         sx, sy, sz, best, bestd, d, dx, dy, dz, tot, nx, ny, nz, acount, ocount;
    r = '0;
    if (w.func == FUNC_START) begin
      fwd_tree.delete();
      back_tree.delete();
      fwd_tree.insert(fwd_tree.size(), '{0, 0, 0, 0});
      back_tree.insert(back_tree.size(), '{SIDE - 1, SIDE - 1, SIDE - 1, 0});
      fwd_count = 1;
      back_count = 1;
      joined = 1'b0;
    end else if (w.func == FUNC_MARK) begin
      blocked_vox[{w.coord_x, w.coord_y, w.coord_z}] = 1'b1;
    end else if (w.func == FUNC_GROW) begin
      if (fwd_count == 0 || back_count == 0) begin
        r.status = ST_NOT_START;
      end else if (joined) begin
        r.status = ST_ALREADY;
      end else begin
        use_fwd = (fwd_count <= back_count);
        r.grew_start_tree = use_fwd;
        acount = use_fwd ? fwd_count : back_count;
        ocount = use_fwd ? back_count : fwd_count;
        if (acount >= MAXN) begin
          r.status = ST_FULL;
        end else begin
          sx = w.coord_x;
          sy = w.coord_y;
          sz = w.coord_z;
          if (w.snap_to_other_root) begin
            sx = use_fwd ? SIDE - 1 : 0;
            sy = sx;
            sz = sx;
          end
          // First nearest node of the active tree.
          best = 0;
          bestd = 32'h7fffffff;
          for (int i = 0; i < acount; i++) begin
            d = sq_dist(sx, sy, sz, use_fwd ? fwd_tree[i] : back_tree[i]);
            if (d < bestd) begin
              bestd = d;
              best = i;
            end
          end
          near_node = use_fwd ? fwd_tree[best] : back_tree[best];
          dx = sx - near_node.x;
          dy = sy - near_node.y;
          dz = sz - near_node.z;
          tot = dx * dx + dy * dy + dz * dz;
          if (tot == 0) begin
            r.status = ST_SAME;
          end else begin
            nx = near_node.x + unit_move(dx, tot);
            ny = near_node.y + unit_move(dy, tot);
            nz = near_node.z + unit_move(dz, tot);
            r.new_x = nx[7:0];
            r.new_y = ny[7:0];
            r.new_z = nz[7:0];
            if (nx < 0 || ny < 0 || nz < 0 || nx >= SIDE || ny >= SIDE || nz >= SIDE ||
                blocked_vox.exists({nx[7:0], ny[7:0], nz[7:0]})) begin
              r.status = ST_BLOCKED;
            end else begin
              fresh = '{nx, ny, nz, near_node.depth + 1};
              if (use_fwd) begin
                fwd_tree.insert(fwd_tree.size(), fresh);
                fwd_count++;
              end else begin
                back_tree.insert(back_tree.size(), fresh);
                back_count++;
              end
              r.new_index = acount[15:0];
              r.status = ST_ADDED;
              // Look for a touching node in the other tree.
              for (int j = 0; j < ocount; j++) begin
                other = use_fwd ? back_tree[j] : fwd_tree[j];
                if (sq_dist(nx, ny, nz, other) <= 1) begin
                  r.status = ST_CONNECTED;
                  joined = 1'b1;
                  r.partner_index = j[15:0];
                  r.path_len = PATH_W'(fresh.depth + other.depth + 2);
                  break;
                end
              end
            end
          end
        end
      end
    end
    r.start_size = SIZE_W'(fwd_count);
    r.goal_size = SIZE_W'(back_count);
    return r;
  endfunction

  // Sends one word after a random gap and files its expectation.
  // Start stays high after the accepting edge; the next call or the caller drops it.
  task automatic send_word(cmd_t w, bit check_direct, res_t direct_res);
    res_t pred;
    int   gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = predict_grow_step(w);
    if (check_direct && pred != direct_res) begin
      $display("%0t: table row disagrees with prediction: expected %h actual %h",
               $time, direct_res, pred);
      table_errors++;
    end
    pending_results.insert(pending_results.size(), pred);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic cmd_t make_word(logic [1:0] f, int x, int y, int z, bit s);
    cmd_t w;
    w.func = f;
    w.coord_x = x[7:0];
    w.coord_y = y[7:0];
    w.coord_z = z[7:0];
    w.snap_to_other_root = s;
    return w;
  endfunction

  function automatic res_t size_only(logic [2:0] st, int s_sz, int g_sz);
    res_t r;
    r = '0;
    r.status = st;
    r.start_size = SIZE_W'(s_sz);
    r.goal_size = SIZE_W'(g_sz);
    return r;
  endfunction

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_o.status !== exp_res.status ||
            res_o.grew_start_tree !== exp_res.grew_start_tree ||
            res_o.new_x !== exp_res.new_x || res_o.new_y !== exp_res.new_y ||
            res_o.new_z !== exp_res.new_z ||
            res_o.new_index !== exp_res.new_index ||
            res_o.partner_index !== exp_res.partner_index ||
            res_o.path_len !== exp_res.path_len ||
            res_o.start_size !== exp_res.start_size ||
            res_o.goal_size !== exp_res.goal_size) begin
          $display("%0t: result mismatch: expected %h actual %h", $time, exp_res, res_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves either way.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    vector_t plan[$];
    cmd_t    w;
    int      k, roll;
    fwd_count = 0;
    back_count = 0;
    joined = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: grow before start, unused code, extremes, snaps, obstacles.
    plan.insert(plan.size(),
                '{make_word(FUNC_GROW, 9, 9, 9, 0), 1, size_only(ST_NOT_START, 0, 0)});
    plan.insert(plan.size(),
                '{make_word(FUNC_UNUSED, 255, 255, 255, 1), 1, size_only(ST_ACK, 0, 0)});
    plan.insert(plan.size(),
                '{make_word(FUNC_MARK, 255, 255, 255, 1), 1, size_only(ST_ACK, 0, 0)});
    plan.insert(plan.size(),
                '{make_word(FUNC_START, 170, 85, 170, 1), 1, size_only(ST_ACK, 1, 1)});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 0, 0, 0, 0), 0, '0});
    plan.insert(plan.size(),
                '{make_word(FUNC_MARK, 1, 1, 1, 0), 1, size_only(ST_ACK, 1, 1)});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 200, 200, 200, 0), 0, '0});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 9, 0, 0, 0), 0, '0});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 255, 255, 255, 0), 0, '0});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 0, 255, 0, 1), 0, '0});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 85, 170, 85, 0), 0, '0});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 255, 0, 255, 0), 0, '0});
    plan.insert(plan.size(),
                '{make_word(FUNC_START, 0, 0, 0, 0), 1, size_only(ST_ACK, 1, 1)});
    // Mark the voxel diagonally next to the goal root so its step toward the start root is blocked.
    plan.insert(plan.size(), '{make_word(FUNC_MARK, 254, 254, 254, 0), 0, '0});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 3, 0, 0, 0), 0, '0});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 0, 0, 0, 1), 0, '0});
    plan.insert(plan.size(), '{make_word(FUNC_GROW, 255, 255, 255, 0), 0, '0});
    for (int i = 0; i < plan.size(); i++)
      send_word(plan[i].word, plan[i].check_direct, plan[i].direct_res);

    // Hold off until every expected result is back.
    start <= 1'b0;
    wait_drained();

    // Random plans: a hundred words, mostly snapped grows on a small obstacle set.
    k = 0;
    while (k < 100) begin
      roll = $urandom_range(0, 99);
      if (roll < 6)
        w = make_word(FUNC_START, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      else if (roll < 14)
        w = make_word(FUNC_MARK, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      else if (roll < 18)
        w = make_word(FUNC_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      else if (roll < 60)
        w = make_word(FUNC_GROW, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), 1'b1);
      else
        w = make_word(FUNC_GROW, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      // Near the diagonal obstacles actually get in the way.
      if (w.func == FUNC_MARK && roll < 12) begin
        w.coord_y = w.coord_x + 8'($urandom_range(0, 1));
        w.coord_z = w.coord_x + 8'($urandom_range(0, 1));
      end
      send_word(w, 0, '0);
      k++;
    end

    start <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (error_count + table_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
